// ===== hdl/window_value_range_tracker_top_defines.svh =====
// assertion macros for the window value range tracker
`ifndef WINDOW_VALUE_RANGE_TRACKER_TOP_DEFINES_SVH
`define WINDOW_VALUE_RANGE_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WVRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WVRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wvrt_pkg.sv =====
// shared constants and types of the window value range tracker
package wvrt_pkg;
  localparam int unsigned TIME_BITS     = 48;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned CFG_BITS      = 48;
  localparam logic [31:0] LOG10_OF_2_Q32 = 32'd1292913986;
  localparam logic [31:0] RECIP_5        = 32'hCCCC_CCCD;

  localparam logic [1:0] REG_WINDOW_START = 2'd0;
  localparam logic [1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [1:0] REG_LOG_SCALE    = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOG    = 8'b0000_0010,
    ST_EVAL   = 8'b0000_0100,
    ST_DIV_S  = 8'b0000_1000,
    ST_DIV_E  = 8'b0001_0000,
    ST_COMMIT = 8'b0010_0000,
    ST_REPORT = 8'b0100_0000,
    ST_PAD    = 8'b1000_0000
  } top_state_e;
endpackage

// ===== hdl/wvrt_log.sv =====
// iterative log10 unit: normalize, square for each fraction bit, scale by log10(2)
module wvrt_log import wvrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] result_o
);
  typedef enum logic [4:0] {
    LG_IDLE = 5'b00001,
    LG_NORM = 5'b00010,
    LG_SQR  = 5'b00100,
    LG_MUL  = 5'b01000,
    LG_FIN  = 5'b10000
  } log_state_e;

  localparam int unsigned SHIFT_S = 64 - FRACTION_BITS;
  localparam logic [63:0] ROUND_T = 64'd1 << (SHIFT_S - 1);
  localparam logic [63:0] CONST_H = {48'd0, LOG10_OF_2_Q32[31:16]};
  localparam logic [63:0] CONST_L = {48'd0, LOG10_OF_2_Q32[15:0]};

  log_state_e  state_q, state_d;
  logic [30:0] m_q, m_d;
  logic [4:0]  p_q, p_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] frac_q, frac_d;
  logic [63:0] a_q, a_d, t_q, t_d;
  logic [63:0] sq;
  logic [31:0] msq;
  logic signed [6:0] whole;
  logic        neg;
  logic [6:0]  whole_abs;
  logic [63:0] mag;
  logic [63:0] rsum;

  assign sq   = {33'd0, m_q} * {33'd0, m_q};
  assign msq  = sq[61:30];
  assign whole = $signed({2'b00, p_q}) - $signed(7'(FRACTION_BITS));
  assign neg  = whole[6];
  assign whole_abs = neg ? 7'(-whole) : 7'(whole);
  assign mag  = neg ? ({25'd0, whole_abs, 32'd0} - {32'd0, frac_q})
                    : ({25'd0, whole_abs, 32'd0} + {32'd0, frac_q});
  assign rsum = (a_q + (t_q >> 16)) >> (SHIFT_S - 16);

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    a_d     = a_q;
    t_d     = t_q;
    done_o  = 1'b0;
    unique case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          m_d     = value_i[30:0];
          p_d     = 5'd30;
          cnt_d   = 5'd0;
          frac_d  = '0;
          state_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (p_q != 5'd0 && !m_q[30]) begin
          m_d = {m_q[29:0], 1'b0};
          p_d = p_q - 5'd1;
        end else begin
          state_d = LG_SQR;
        end
      end
      LG_SQR: begin
        m_d    = msq[31] ? msq[31:1] : msq[30:0];
        frac_d = {frac_q[30:0], msq[31]};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = LG_MUL;
      end
      LG_MUL: begin
        a_d     = mag * CONST_H;
        t_d     = mag * CONST_L + ROUND_T;
        state_d = LG_FIN;
      end
      LG_FIN: begin
        done_o  = 1'b1;
        state_d = LG_IDLE;
      end
      default: state_d = LG_IDLE;
    endcase
  end

  assign result_o = neg ? (32'd0 - rsum[31:0]) : rsum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    p_q    <= p_d;
    cnt_q  <= cnt_d;
    frac_q <= frac_d;
    a_q    <= a_d;
    t_q    <= t_d;
  end
endmodule

// ===== hdl/wvrt_div.sv =====
// bit-serial interpolation: low + sign * round(|high-low| * num / den)
module wvrt_div import wvrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] low_i,
  input  logic [VALUE_BITS-1:0] high_i,
  input  logic [TIME_BITS-1:0]  num_i,
  input  logic [TIME_BITS-1:0]  den_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] result_o
);
  typedef enum logic [4:0] {
    DV_IDLE = 5'b00001,
    DV_DBL  = 5'b00010,
    DV_ADD  = 5'b00100,
    DV_RND  = 5'b01000,
    DV_FIN  = 5'b10000
  } div_state_e;

  div_state_e           state_q, state_d;
  logic [31:0]          low_q, low_d;
  logic                 neg_q, neg_d;
  logic [32:0]          d_q, d_d;
  logic [TIME_BITS-1:0] num_q, num_d, den_q, den_d, r_q, r_d;
  logic [33:0]          q_q, q_d;
  logic [5:0]           b_q, b_d;
  logic [32:0]          diff;
  logic [TIME_BITS-1:0] addend;
  logic [TIME_BITS:0]   sum, sum_red;
  logic                 wrap;

  assign diff = {high_i[31], high_i} - {low_i[31], low_i};

  // shared modular adder: sum of remainder and addend, reduced once by den
  assign addend  = state_q == DV_DBL ? r_q : num_q;
  assign sum     = {1'b0, r_q} + {1'b0, addend};
  assign wrap    = sum >= {1'b0, den_q};
  assign sum_red = wrap ? sum - {1'b0, den_q} : sum;

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    neg_d   = neg_q;
    d_d     = d_q;
    num_d   = num_q;
    den_d   = den_q;
    r_d     = r_q;
    q_d     = q_q;
    b_d     = b_q;
    done_o  = 1'b0;
    unique case (state_q)
      DV_IDLE: ;
      DV_DBL: begin
        r_d     = sum_red[TIME_BITS-1:0];
        q_d     = {q_q[32:0], 1'b0} + {33'd0, wrap};
        state_d = DV_ADD;
      end
      DV_ADD: begin
        if (d_q[b_q]) begin
          r_d = sum_red[TIME_BITS-1:0];
          q_d = q_q + {33'd0, wrap};
        end
        if (b_q == 6'd0) begin
          state_d = DV_RND;
        end else begin
          b_d     = b_q - 6'd1;
          state_d = DV_DBL;
        end
      end
      DV_RND: begin
        // round half away from zero on the magnitude
        if ({r_q, 1'b0} >= {1'b0, den_q}) q_d = q_q + 34'd1;
        state_d = DV_FIN;
      end
      DV_FIN: begin
        done_o  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
    // a new start is taken when idle or in the cycle that hands out a result
    if (start_i && (state_q == DV_IDLE || state_q == DV_FIN)) begin
      low_d   = low_i;
      neg_d   = diff[32];
      d_d     = diff[32] ? 33'd0 - diff : diff;
      num_d   = num_i;
      den_d   = den_i;
      r_d     = '0;
      q_d     = '0;
      b_d     = 6'd32;
      state_d = DV_DBL;
    end
  end

  assign result_o = neg_q ? low_q - q_q[31:0] : low_q + q_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
    neg_q <= neg_d;
    d_q   <= d_d;
    num_q <= num_d;
    den_q <= den_d;
    r_q   <= r_d;
    q_q   <= q_d;
    b_q   <= b_d;
  end
endmodule

// ===== hdl/window_value_range_tracker_top.sv =====
// top level: sequencer, running range, boundary crossings, padding and output register
//
// channel    dir  payload
// s_axis     in   tdata: sample_time, sample_value; tuser: value_finite, plotable; tlast
// m_axis     out  tdata: range_minimum, range_maximum; tuser: range_found
// cfg        in   cfg_we_i, cfg_addr_i, cfg_data_i (window_start, window_end, log_scale)
//
// one sample at a time; log mode adds a pass through the squaring log unit,
// each boundary crossing a pass through the bit-serial divider (a doubling
// step and an adding step per result bit), a last sample adds report and padding states.
// s_axis_tready is high only while the sequencer is idle.
// the result register holds a pending transaction while m_axis_tready is low;
// a later report waits for it. reset is asynchronous and needs no clearing pass.
`include "window_value_range_tracker_top_defines.svh"
module window_value_range_tracker_top import wvrt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_addr_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [79:0]   s_axis_tdata,  // sample_time [47:0], sample_value [79:48]
  input  logic [1:0]    s_axis_tuser,  // value_finite [0], plotable [1]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,  // range_minimum [31:0], range_maximum [63:32]
  output logic [0:0]    m_axis_tuser   // range_found [0]
);
  top_state_e state_q, state_d;

  logic [TIME_BITS-1:0] ws_q, we_q;
  logic                 log_q;
  logic [TIME_BITS-1:0] t_q;
  logic [31:0]          pv_q, pv_d;
  logic                 usable_q, last_q;
  logic [31:0]          min_q, max_q;
  logic                 any_q;
  logic [TIME_BITS-1:0] prev_time_q;
  logic [31:0]          prev_pv_q;
  logic                 prev_usable_q, have_prev_q;
  logic [28:0]          pad_q;
  logic                 out_valid_q, found_q;
  logic [31:0]          omin_q, omax_q;

  logic                 accept;
  logic [TIME_BITS-1:0] in_time;
  logic [31:0]          in_value;
  logic                 in_pos;
  logic                 log_start, log_done;
  logic [31:0]          log_result;
  logic                 div_start, div_done;
  logic [31:0]          div_result;
  logic [TIME_BITS-1:0] div_num;
  logic                 pair_ok, cross_s, cross_e;
  logic                 inc_en;
  logic [31:0]          inc_val;
  logic                 clear_set;
  logic                 out_free;
  logic [31:0]          mag;
  logic [32:0]          mag_rnd;
  logic [62:0]          pad_prod;
  logic [28:0]          pad_eff;
  logic signed [33:0]   lo_w, hi_w;
  logic [31:0]          lo_sat, hi_sat;
  logic                 found_d;

  assign in_time  = s_axis_tdata[TIME_BITS-1:0];
  assign in_value = s_axis_tdata[TIME_BITS +: VALUE_BITS];
  assign in_pos   = !in_value[31] && (in_value != 32'd0);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;
  assign out_free = !out_valid_q || m_axis_tready;

  assign pair_ok = usable_q && have_prev_q && prev_usable_q;
  assign cross_s = pair_ok && (prev_time_q < ws_q) && (ws_q < t_q);
  assign cross_e = pair_ok && (prev_time_q < we_q) && (we_q < t_q);

  assign log_start = accept && log_q && in_pos;
  assign div_num   = (state_q == ST_EVAL && cross_s) ? ws_q - prev_time_q
                                                     : we_q - prev_time_q;
  assign div_start = (state_q == ST_EVAL && (cross_s || cross_e)) ||
                     (state_q == ST_DIV_S && div_done && cross_e);

  wvrt_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .value_i  (in_value),
    .done_o   (log_done),
    .result_o (log_result)
  );

  wvrt_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .low_i    (prev_pv_q),
    .high_i   (pv_q),
    .num_i    (div_num),
    .den_i    (t_q - prev_time_q),
    .done_o   (div_done),
    .result_o (div_result)
  );

  // padding of a flat range: round(|v| / 20) as ((|v| + 10) >> 2) / 5
  assign mag      = min_q[31] ? 32'd0 - min_q : min_q;
  assign mag_rnd  = {1'b0, mag} + 33'd10;
  assign pad_prod = {32'd0, mag_rnd[32:2]} * {31'd0, RECIP_5};
  assign pad_eff  = (min_q == 32'd0) ? 29'(32'd1 << FRACTION_BITS)
                  : (pad_q == 29'd0) ? 29'd1 : pad_q;
  assign lo_w = (min_q == max_q) ? $signed({{2{min_q[31]}}, min_q}) - $signed({5'd0, pad_eff})
                                 : $signed({{2{min_q[31]}}, min_q});
  assign hi_w = (min_q == max_q) ? $signed({{2{max_q[31]}}, max_q}) + $signed({5'd0, pad_eff})
                                 : $signed({{2{max_q[31]}}, max_q});
  assign lo_sat = (lo_w < -34'sd2147483648) ? 32'h8000_0000 : lo_w[31:0];
  assign hi_sat = (hi_w > 34'sd2147483647)  ? 32'h7FFF_FFFF : hi_w[31:0];
  assign found_d = any_q && (ws_q <= we_q);

  always_comb begin
    state_d   = state_q;
    pv_d      = pv_q;
    inc_en    = 1'b0;
    inc_val   = pv_q;
    clear_set = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pv_d    = log_q ? 32'd0 : in_value;
          state_d = log_start ? ST_LOG : ST_EVAL;
        end
      end
      ST_LOG: begin
        if (log_done) begin
          pv_d    = log_result;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        inc_en = usable_q && (ws_q <= t_q) && (t_q <= we_q);
        if (cross_s) state_d = ST_DIV_S;
        else if (cross_e) state_d = ST_DIV_E;
        else state_d = ST_COMMIT;
      end
      ST_DIV_S: begin
        if (div_done) begin
          inc_en  = 1'b1;
          inc_val = div_result;
          state_d = cross_e ? ST_DIV_E : ST_COMMIT;
        end
      end
      ST_DIV_E: begin
        if (div_done) begin
          inc_en  = 1'b1;
          inc_val = div_result;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = last_q ? ST_REPORT : ST_IDLE;
      ST_REPORT: state_d = ST_PAD;
      ST_PAD: begin
        if (out_free) begin
          clear_set = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ws_q          <= '0;
      we_q          <= '1;
      log_q         <= 1'b0;
      min_q         <= 32'h7FFF_FFFF;
      max_q         <= 32'h8000_0000;
      any_q         <= 1'b0;
      prev_time_q   <= '0;
      prev_pv_q     <= '0;
      prev_usable_q <= 1'b0;
      have_prev_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_WINDOW_START: ws_q  <= cfg_data_i[TIME_BITS-1:0];
          REG_WINDOW_END:   we_q  <= cfg_data_i[TIME_BITS-1:0];
          REG_LOG_SCALE:    log_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (inc_en) begin
        if ($signed(inc_val) < $signed(min_q)) min_q <= inc_val;
        if ($signed(inc_val) > $signed(max_q)) max_q <= inc_val;
        any_q <= 1'b1;
      end
      if (state_q == ST_COMMIT) begin
        prev_time_q   <= t_q;
        prev_pv_q     <= pv_q;
        prev_usable_q <= usable_q;
        have_prev_q   <= 1'b1;
      end
      if (clear_set) begin
        min_q         <= 32'h7FFF_FFFF;
        max_q         <= 32'h8000_0000;
        any_q         <= 1'b0;
        prev_time_q   <= '0;
        prev_pv_q     <= '0;
        prev_usable_q <= 1'b0;
        have_prev_q   <= 1'b0;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= pv_d;
    if (accept) begin
      t_q      <= in_time;
      usable_q <= s_axis_tuser[0] && s_axis_tuser[1] && (!log_q || in_pos);
      last_q   <= s_axis_tlast;
    end
    if (state_q == ST_REPORT) pad_q <= pad_prod[62:34];
    if (clear_set) begin
      found_q <= found_d;
      omin_q  <= found_d ? lo_sat : 32'd0;
      omax_q  <= found_d ? hi_sat : 32'd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {omax_q, omin_q};
  assign m_axis_tuser  = found_q;

  `WVRT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !s_axis_tready,
                    "input accepted but block still ready")
  `WVRT_ASSERT_NOW(a_log_done_in_log, clk_i, rst_ni, log_done, state_q == ST_LOG,
                   "log unit finished outside log wait")
  `WVRT_ASSERT_NOW(a_div_done_in_div, clk_i, rst_ni, div_done,
                   state_q == ST_DIV_S || state_q == ST_DIV_E,
                   "divider finished outside crossing wait")
  `WVRT_ASSERT_NEXT(a_report_from_pad, clk_i, rst_ni, clear_set,
                    m_axis_tvalid && state_q == ST_IDLE,
                    "report not loaded into result register")
endmodule
